/* rtl/tmslm_pkg.sv */
// ----------------------------------------------------------------------------
// tmslm_pkg
// shared types and codes of the three-mode shared lock manager
// ----------------------------------------------------------------------------
`default_nettype none

package tmslm_pkg;

	localparam int WAIT_DEPTH_DEF    = 16;
	localparam int LOCATION_BITS_DEF = 8;
	localparam int TAG_BITS_DEF      = 16;

	typedef enum logic [1:0] {
		MODE_ACQUIRE = 2'd0,
		MODE_RELEASE = 2'd1,
		MODE_FREE    = 2'd2,
		MODE_BAD     = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		ACC_READ = 2'd0,
		ACC_EW   = 2'd1,
		ACC_ITW  = 2'd2,
		ACC_BAD  = 2'd3
	} acc_t;

	typedef enum logic [1:0] {
		LOCK_NONE = 2'd0,
		LOCK_EW   = 2'd1,
		LOCK_ITW  = 2'd2
	} lock_t;

	typedef enum logic [2:0] {
		ST_GRANTED  = 3'd0,
		ST_PARKED   = 3'd1,
		ST_ACC_ERR  = 3'd2,
		ST_WAITER   = 3'd3,
		ST_RELEASED = 3'd4,
		ST_DESTROY  = 3'd5,
		ST_FREED    = 3'd6,
		ST_FULL     = 3'd7
	} status_t;

	typedef enum logic [2:0] {
		FSM_IDLE,
		FSM_RD,
		FSM_EW,
		FSM_ITW,
		FSM_FLUSH,
		FSM_PACK,
		FSM_DESTROY
	} fsm_t;

endpackage

`default_nettype wire

/* rtl/tmslm_wait_mem.sv */
// ----------------------------------------------------------------------------
// tmslm_wait_mem
// wait store memory, one write port, one read port, registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module tmslm_wait_mem #(
	parameter int WIDTH     = 34,
	parameter int ADDR_BITS = 6
) (
	input  wire logic                 clk,
	input  wire logic                 we,
	input  wire logic [ADDR_BITS-1:0] waddr,
	input  wire logic [WIDTH-1:0]     wdata,
	input  wire logic                 re,
	input  wire logic [ADDR_BITS-1:0] raddr,
	output logic      [WIDTH-1:0]     rdata
);

	logic [WIDTH-1:0] mem_q [2**ADDR_BITS];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

/* rtl/three_mode_shared_lock_manager.sv */
// ----------------------------------------------------------------------------
// three_mode_shared_lock_manager
// reader / exclusive / intra-location writer lock with lifo wait stores
// ----------------------------------------------------------------------------
// channel   ports                                     transaction when
// request   start busy mode access_kind requester_*    start && !busy
//           runtime_access bypass_locking
// result    done status grantee_* user_error last      done
//
// acquire, free request and a non-final release need no walk: the result
// shows the next cycle and busy stays low. a final release with parked
// waiters walks the wait store memory, one read per cycle: all parked readers
// are granted, or one parked exclusive writer, or the parked intra-location
// writers (grant pass, then compaction pass). busy is high while a walk runs.
// reset is asynchronous; the wait stores need no clearing.
// ----------------------------------------------------------------------------
`default_nettype none

module three_mode_shared_lock_manager #(
	parameter int WAIT_DEPTH    = tmslm_pkg::WAIT_DEPTH_DEF,
	parameter int LOCATION_BITS = tmslm_pkg::LOCATION_BITS_DEF,
	parameter int TAG_BITS      = tmslm_pkg::TAG_BITS_DEF
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     start,
	output logic                          busy,
	input  wire logic [1:0]               mode,
	input  wire logic [1:0]               access_kind,
	input  wire logic [TAG_BITS-1:0]      requester_id,
	input  wire logic [7:0]               requester_slot,
	input  wire logic [LOCATION_BITS-1:0] requester_location,
	input  wire logic                     runtime_access,
	input  wire logic                     bypass_locking,
	output logic                          done,
	output logic [2:0]                    status,
	output logic [TAG_BITS-1:0]           grantee_id,
	output logic [7:0]                    grantee_slot,
	output logic                          grantee_runtime,
	output logic [1:0]                    grantee_access,
	output logic                          user_error,
	output logic                          last
);

	import tmslm_pkg::*;

	localparam int IDXW = (WAIT_DEPTH > 1) ? $clog2(WAIT_DEPTH) : 1;
	localparam int CW   = $clog2(WAIT_DEPTH + 1);
	localparam int EW   = TAG_BITS + 8 + LOCATION_BITS + 1;
	localparam int AW   = IDXW + 2;

	fsm_t state_q, state_d;

	logic [7:0]               uc_q, uc_d;
	logic [1:0]               lock_q, lock_d;
	logic [LOCATION_BITS-1:0] wloc_q, wloc_d;
	logic                     fp_q, fp_d;
	logic [CW-1:0]            cnt_q [3];
	logic [CW-1:0]            cnt_d [3];

	logic [IDXW-1:0]          ptr_q, ptr_d;
	logic [CW-1:0]            rem_q, rem_d;
	logic [CW-1:0]            j_q, j_d;
	logic                     fst_q, fst_d;
	logic [1:0]               sel_q, sel_d;
	logic [LOCATION_BITS-1:0] eloc_q, eloc_d;
	logic [EW-1:0]            hold_q, hold_d;
	logic                     hold_v_q, hold_v_d;
	logic [TAG_BITS-1:0]      sid_q, sid_d;
	logic [7:0]               sslot_q, sslot_d;
	logic                     srt_q, srt_d;

	logic                     vld_s1, end_s1, first_s1;

	logic                     done_d, uerr_d, last_d;
	logic [2:0]               status_d;
	logic [TAG_BITS-1:0]      gid_d;
	logic [7:0]               gslot_d;
	logic                     grt_d;
	logic [1:0]               gacc_d;

	logic                     we, re;
	logic [AW-1:0]            waddr, raddr;
	logic [EW-1:0]            wdata, rdata;

	logic                     accept, issue, is_walk;
	logic [7:0]               uc_inc;
	logic                     rel_final, go_rd, go_itw, go_ew, go_dst;
	logic [TAG_BITS-1:0]      e_id, h_id;
	logic [7:0]               e_slot, h_slot;
	logic [LOCATION_BITS-1:0] e_loc;
	logic                     e_rt, h_rt, e_match;
	logic                     park;

	tmslm_wait_mem #(
		.WIDTH     (EW),
		.ADDR_BITS (AW)
	) u_mem (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (re),
		.raddr (raddr),
		.rdata (rdata)
	);

	assign busy   = (state_q != FSM_IDLE);
	assign accept = start && !busy;
	assign uc_inc = (uc_q == 8'hFF) ? uc_q : uc_q + 8'd1;

	assign e_id   = rdata[EW-1 -: TAG_BITS];
	assign e_slot = rdata[LOCATION_BITS+1 +: 8];
	assign e_loc  = rdata[1 +: LOCATION_BITS];
	assign e_rt   = rdata[0];
	assign h_id   = hold_q[EW-1 -: TAG_BITS];
	assign h_slot = hold_q[LOCATION_BITS+1 +: 8];
	assign h_rt   = hold_q[0];
	assign e_match = first_s1 || (e_loc == eloc_q);

	// final release decisions
	assign rel_final = (mode == MODE_RELEASE) && (uc_q == 8'd1);
	assign go_rd  = rel_final && (lock_q != LOCK_NONE) && (cnt_q[0] != '0);
	assign go_itw = rel_final && !go_rd && (cnt_q[2] != '0);
	assign go_ew  = rel_final && !go_rd && !go_itw && (cnt_q[1] != '0);
	assign go_dst = rel_final && !go_rd && !go_itw && !go_ew && fp_q;

	always_comb begin
		case (access_kind)
			ACC_READ: park = (lock_q != LOCK_NONE);
			ACC_EW:   park = (lock_q != LOCK_NONE) || (uc_q != 8'd0);
			default: begin
				if (lock_q == LOCK_ITW) begin
					park = (requester_location != wloc_q);
				end else begin
					park = (uc_q != 8'd0) || (lock_q == LOCK_EW);
				end
			end
		endcase
	end

	assign is_walk = (state_q == FSM_RD) || (state_q == FSM_EW) ||
			(state_q == FSM_ITW) || (state_q == FSM_PACK);
	assign issue = is_walk && (rem_q != '0);
	assign re    = issue;
	assign raddr = {sel_q, ptr_q};

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			FSM_IDLE: begin
				if (accept) begin
					if (go_rd) begin
						state_d = FSM_RD;
					end else if (go_itw) begin
						state_d = FSM_ITW;
					end else if (go_ew) begin
						state_d = FSM_EW;
					end else if (go_dst) begin
						state_d = FSM_DESTROY;
					end
				end
			end
			FSM_RD: begin
				if (vld_s1 && end_s1) state_d = FSM_IDLE;
			end
			FSM_EW: begin
				if (vld_s1) state_d = FSM_IDLE;
			end
			FSM_ITW: begin
				if (vld_s1 && end_s1) state_d = FSM_FLUSH;
			end
			FSM_FLUSH:   state_d = FSM_PACK;
			FSM_PACK: begin
				if (vld_s1 && end_s1) state_d = FSM_IDLE;
			end
			FSM_DESTROY: state_d = FSM_IDLE;
			default:     state_d = FSM_IDLE;
		endcase
	end

	// datapath and outputs
	always_comb begin
		uc_d     = uc_q;
		lock_d   = lock_q;
		wloc_d   = wloc_q;
		fp_d     = fp_q;
		cnt_d    = cnt_q;
		ptr_d    = ptr_q;
		rem_d    = rem_q;
		j_d      = j_q;
		fst_d    = fst_q;
		sel_d    = sel_q;
		eloc_d   = eloc_q;
		hold_d   = hold_q;
		hold_v_d = hold_v_q;
		sid_d    = sid_q;
		sslot_d  = sslot_q;
		srt_d    = srt_q;
		done_d   = 1'b0;
		status_d = ST_GRANTED;
		gid_d    = requester_id;
		gslot_d  = requester_slot;
		grt_d    = runtime_access;
		gacc_d   = ACC_READ;
		uerr_d   = 1'b0;
		last_d   = 1'b1;
		we       = 1'b0;
		waddr    = {access_kind, ptr_q};
		wdata    = {requester_id, requester_slot, requester_location, runtime_access};

		if (issue) begin
			ptr_d = (state_q == FSM_PACK) ? ptr_q + IDXW'(1) : ptr_q - IDXW'(1);
			rem_d = rem_q - CW'(1);
			fst_d = 1'b0;
		end

		case (state_q)
			FSM_IDLE: begin
				if (accept) begin
					done_d  = 1'b1;
					sid_d   = requester_id;
					sslot_d = requester_slot;
					srt_d   = runtime_access;
					case (mode)
						MODE_ACQUIRE: begin
							gacc_d = access_kind;
							if ((fp_q && uc_q == 8'd0) || access_kind == ACC_BAD) begin
								status_d = ST_ACC_ERR;
							end else if (bypass_locking) begin
								status_d = ST_GRANTED;
							end else if (park) begin
								if (cnt_q[access_kind] >= CW'(WAIT_DEPTH)) begin
									status_d = ST_FULL;
								end else begin
									we    = 1'b1;
									waddr = {access_kind, cnt_q[access_kind][IDXW-1:0]};
									cnt_d[access_kind] = cnt_q[access_kind] + CW'(1);
									status_d = ST_PARKED;
								end
							end else if (uc_q == 8'hFF) begin
								status_d = ST_ACC_ERR;
							end else begin
								if (access_kind == ACC_EW) lock_d = LOCK_EW;
								if (access_kind == ACC_ITW && uc_q == 8'd0) begin
									lock_d = LOCK_ITW;
									wloc_d = requester_location;
								end
								uc_d = uc_q + 8'd1;
								status_d = ST_GRANTED;
							end
						end
						MODE_RELEASE: begin
							status_d = ST_RELEASED;
							if (uc_q == 8'd0) begin
								uerr_d = 1'b1;
							end else begin
								uc_d = uc_q - 8'd1;
								if (rel_final && lock_q != LOCK_NONE) begin
									lock_d = LOCK_NONE;
									wloc_d = '1;
								end
								last_d = !(go_rd || go_itw || go_ew || go_dst);
								if (go_rd) begin
									sel_d = ACC_READ;
									ptr_d = IDXW'(cnt_q[0] - CW'(1));
									rem_d = cnt_q[0];
								end else if (go_itw) begin
									sel_d    = ACC_ITW;
									ptr_d    = IDXW'(cnt_q[2] - CW'(1));
									rem_d    = cnt_q[2];
									fst_d    = 1'b1;
									hold_v_d = 1'b0;
								end else if (go_ew) begin
									sel_d = ACC_EW;
									ptr_d = IDXW'(cnt_q[1] - CW'(1));
									rem_d = CW'(1);
								end
							end
						end
						MODE_FREE: begin
							if (fp_q) begin
								status_d = ST_FREED;
							end else begin
								fp_d = 1'b1;
								status_d = (uc_q == 8'd0) ? ST_DESTROY : ST_GRANTED;
							end
						end
						default: status_d = ST_ACC_ERR;
					endcase
				end
			end
			FSM_RD: begin
				if (vld_s1) begin
					done_d = 1'b1; status_d = ST_WAITER;
					gid_d = e_id; gslot_d = e_slot; grt_d = e_rt; gacc_d = ACC_READ;
					last_d = end_s1;
					uc_d = uc_inc;
					if (end_s1) cnt_d[0] = '0;
				end
			end
			FSM_EW: begin
				if (vld_s1) begin
					done_d = 1'b1; status_d = ST_WAITER;
					gid_d = e_id; gslot_d = e_slot; grt_d = e_rt; gacc_d = ACC_EW;
					uc_d = uc_inc;
					lock_d = LOCK_EW;
					cnt_d[1] = cnt_q[1] - CW'(1);
				end
			end
			FSM_ITW: begin
				if (vld_s1) begin
					if (first_s1) begin
						eloc_d = e_loc;
						wloc_d = e_loc;
						lock_d = LOCK_ITW;
					end
					if (e_match) begin
						if (hold_v_q) begin
							done_d = 1'b1; status_d = ST_WAITER;
							gid_d = h_id; gslot_d = h_slot; grt_d = h_rt; gacc_d = ACC_ITW;
							last_d = 1'b0;
							uc_d = uc_inc;
						end
						hold_d   = rdata;
						hold_v_d = 1'b1;
					end
				end
			end
			FSM_FLUSH: begin
				done_d = 1'b1; status_d = ST_WAITER;
				gid_d = h_id; gslot_d = h_slot; grt_d = h_rt; gacc_d = ACC_ITW;
				uc_d  = uc_inc;
				ptr_d = '0;
				rem_d = cnt_q[2];
				j_d   = '0;
			end
			FSM_PACK: begin
				if (vld_s1) begin
					if (e_loc != eloc_q) begin
						we    = 1'b1;
						waddr = {ACC_ITW, j_q[IDXW-1:0]};
						wdata = rdata;
						j_d   = j_q + CW'(1);
					end
					if (end_s1) cnt_d[2] = j_d;
				end
			end
			FSM_DESTROY: begin
				done_d = 1'b1; status_d = ST_DESTROY;
				gid_d = sid_q; gslot_d = sslot_q; grt_d = srt_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= FSM_IDLE;
			uc_q     <= '0;
			lock_q   <= LOCK_NONE;
			wloc_q   <= '1;
			fp_q     <= 1'b0;
			cnt_q    <= '{default: '0};
			rem_q    <= '0;
			hold_v_q <= 1'b0;
			vld_s1   <= 1'b0;
			done     <= 1'b0;
		end else begin
			state_q  <= state_d;
			uc_q     <= uc_d;
			lock_q   <= lock_d;
			wloc_q   <= wloc_d;
			fp_q     <= fp_d;
			cnt_q    <= cnt_d;
			rem_q    <= rem_d;
			hold_v_q <= hold_v_d;
			vld_s1   <= issue;
			done     <= done_d;
		end
	end

	always_ff @(posedge clk) begin
		ptr_q           <= ptr_d;
		j_q             <= j_d;
		fst_q           <= fst_d;
		sel_q           <= sel_d;
		eloc_q          <= eloc_d;
		hold_q          <= hold_d;
		sid_q           <= sid_d;
		sslot_q         <= sslot_d;
		srt_q           <= srt_d;
		end_s1          <= (rem_q == CW'(1));
		first_s1        <= fst_q;
		status          <= status_d;
		grantee_id      <= gid_d;
		grantee_slot    <= gslot_d;
		grantee_runtime <= grt_d;
		grantee_access  <= gacc_d;
		user_error      <= uerr_d;
		last            <= last_d;
	end

	// every accepted transaction gives a result in the next cycle
	a_accept_result: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> done)
		else $error("accepted transaction without result");

	// a non-final result only while the manager is still busy
	a_more_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done && !last |-> busy)
		else $error("non-final result while idle");

	// wait counts never pass the store depth
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q[0] <= CW'(WAIT_DEPTH) && cnt_q[1] <= CW'(WAIT_DEPTH) &&
		cnt_q[2] <= CW'(WAIT_DEPTH))
		else $error("wait count overflow");

	// read data only comes back during a walk
	a_rd_walk: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 |-> (state_q == FSM_RD || state_q == FSM_EW ||
			state_q == FSM_ITW || state_q == FSM_PACK))
		else $error("stray read data");

endmodule

`default_nettype wire
